[rtl/rau_pkg.sv]
// Shared types, codes and widths of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;
  localparam int unsigned CMD_W             = 3;
  localparam int unsigned NUM_W             = 33;
  localparam int unsigned DEN_W             = 31;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_GT  = 3'd5,
    OP_LT  = 3'd6
  } rau_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_FORM,
    ST_OUT
  } rau_state_e;

  typedef enum logic [1:0] {
    JOB_FIRST,
    JOB_SECOND,
    JOB_RESULT
  } rau_job_e;

  typedef enum logic [2:0] {
    PROD_LEFT,
    PROD_RIGHT,
    PROD_NN,
    PROD_DD,
    PROD_DN
  } rau_prod_e;

  // Commands and status of the reduce engine.
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_latch;
    logic div_step;
    logic short_len;
  } rau_red_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } rau_red_sts_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      load_job;
    rau_job_e  job;
    logic      gcd_step;
    logic      gcd_latch;
    logic      div_step;
    logic      write_back;
    logic      mul_en;
    rau_prod_e mul_sel;
    logic      form;
    logic      out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic arith;
    logic out_blocked;
  } rau_sts_t;

endpackage
`default_nettype wire

[rtl/rau_reduce.sv]
// Reduce engine: binary gcd followed by two exact restoring divisions by the gcd.
`timescale 1ns / 1ps
`default_nettype none
module rau_reduce #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rau_pkg::rau_red_cmd_t          cmd_i,
  input  logic [2*OPERAND_WIDTH-1:0]     num_mag_i,
  input  logic [2*OPERAND_WIDTH-1:0]     den_mag_i,
  output rau_pkg::rau_red_sts_t          sts_o,
  output logic [2*OPERAND_WIDTH-1:0]     quo_num_o,
  output logic [2*OPERAND_WIDTH-1:0]     quo_den_o
);
  import rau_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned MW = 2 * W;
  localparam int unsigned KW = $clog2(MW + 1);
  localparam logic [KW-1:0] LEN_SHORT = KW'(W);
  localparam logic [KW-1:0] LEN_FULL  = KW'(MW);

  logic [MW-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [MW-1:0] g_q;
  logic [MW-1:0] xn_q, xd_q;
  logic [MW-1:0] remn_q, remd_q;
  logic [MW-1:0] qn_q, qd_q;
  logic [KW-1:0] cnt_q;

  logic [MW-1:0] diff_ab, diff_ba;
  logic [MW:0]   trial_n, trial_d, g_ext, sub_n, sub_d;
  logic          fit_n, fit_d;

  assign diff_ab = a_q - b_q;
  assign diff_ba = b_q - a_q;

  // Binary gcd step: drop common twos, strip lone twos, halve the odd difference.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load) begin
      a_d = num_mag_i;
      b_d = den_mag_i;
      k_d = '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = diff_ab >> 1;
      end else begin
        b_d = diff_ba >> 1;
      end
    end
  end

  assign g_ext   = {1'b0, g_q};
  assign trial_n = {remn_q, xn_q[MW-1]};
  assign trial_d = {remd_q, xd_q[MW-1]};
  assign sub_n   = trial_n - g_ext;
  assign sub_d   = trial_d - g_ext;
  assign fit_n   = trial_n >= g_ext;
  assign fit_d   = trial_d >= g_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= cmd_i.short_len ? LEN_SHORT : LEN_FULL;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    if (cmd_i.load) begin
      // Short jobs carry only W significant bits: align them to the top.
      xn_q   <= cmd_i.short_len ? {num_mag_i[W-1:0], {W{1'b0}}} : num_mag_i;
      xd_q   <= cmd_i.short_len ? {den_mag_i[W-1:0], {W{1'b0}}} : den_mag_i;
      remn_q <= '0;
      remd_q <= '0;
      qn_q   <= '0;
      qd_q   <= '0;
    end else if (cmd_i.div_step) begin
      xn_q   <= xn_q << 1;
      xd_q   <= xd_q << 1;
      remn_q <= fit_n ? sub_n[MW-1:0] : trial_n[MW-1:0];
      remd_q <= fit_d ? sub_d[MW-1:0] : trial_d[MW-1:0];
      qn_q   <= {qn_q[MW-2:0], fit_n};
      qd_q   <= {qd_q[MW-2:0], fit_d};
    end
    if (cmd_i.gcd_latch) begin
      // One of a and b is zero here, so the or gives the odd part.
      g_q <= (a_q | b_q) << k_q;
    end
  end

  assign sts_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign sts_o.div_done = (cnt_q == '0);
  assign quo_num_o      = qn_q;
  assign quo_den_o      = qd_q;

endmodule
`default_nettype wire

[rtl/rau_datapath.sv]
// Datapath: operand and product registers, shared multiplier, result forming, output register.
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rau_pkg::rau_cmd_t                 cmd_i,
  output rau_pkg::rau_sts_t                 sts_o,
  input  logic [rau_pkg::CMD_W-1:0]         command_i,
  input  logic signed [OPERAND_WIDTH-1:0]   first_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   first_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]   second_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   second_den_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [rau_pkg::NUM_W-1:0]  result_num_o,
  output logic [rau_pkg::DEN_W-1:0]         result_den_o,
  output logic                              compare_flag_o
);
  import rau_pkg::*;

  localparam int unsigned W   = OPERAND_WIDTH;
  localparam int unsigned CW  = W + 1;
  localparam int unsigned MW  = 2 * W;
  localparam int unsigned RW  = 2 * W + 1;
  localparam int unsigned NXW = (RW > NUM_W) ? RW : NUM_W;
  localparam int unsigned DXW = (RW > DEN_W) ? RW : DEN_W;

  rau_op_e              op_q;
  logic signed [CW-1:0] n1_q, d1_q, n2_q, d2_q;
  logic signed [RW-1:0] left_q, right_q, nn_q, dd_q, dn_q;
  logic signed [RW-1:0] rn_q, rd_q;
  logic                 flag_q;
  logic                 neg_q;

  logic                 out_valid_q;
  logic [NUM_W-1:0]     out_num_q;
  logic [DEN_W-1:0]     out_den_q;
  logic                 out_flag_q;

  // Engine source select and magnitudes.
  logic signed [RW-1:0] src_num, src_den, abs_num, abs_den;
  logic [MW-1:0]        num_mag, den_mag;

  always_comb begin
    case (cmd_i.job)
      JOB_FIRST: begin
        src_num = RW'(n1_q);
        src_den = RW'(d1_q);
      end
      JOB_SECOND: begin
        src_num = RW'(n2_q);
        src_den = RW'(d2_q);
      end
      default: begin
        src_num = rn_q;
        src_den = rd_q;
      end
    endcase
  end

  assign abs_num = src_num[RW-1] ? -src_num : src_num;
  assign abs_den = src_den[RW-1] ? -src_den : src_den;
  assign num_mag = abs_num[MW-1:0];
  assign den_mag = abs_den[MW-1:0];

  rau_red_cmd_t        red_cmd;
  rau_red_sts_t        red_sts;
  logic [MW-1:0]       quo_num, quo_den;

  assign red_cmd.load      = cmd_i.load_job;
  assign red_cmd.gcd_step  = cmd_i.gcd_step;
  assign red_cmd.gcd_latch = cmd_i.gcd_latch;
  assign red_cmd.div_step  = cmd_i.div_step;
  assign red_cmd.short_len = (cmd_i.job != JOB_RESULT);

  rau_reduce #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (red_cmd),
    .num_mag_i(num_mag),
    .den_mag_i(den_mag),
    .sts_o    (red_sts),
    .quo_num_o(quo_num),
    .quo_den_o(quo_den)
  );

  // Signed canonical value from the quotients; the sign sits on the numerator.
  logic signed [RW-1:0] quo_num_s, quo_den_s, can_num;
  assign quo_num_s = $signed({1'b0, quo_num});
  assign quo_den_s = $signed({1'b0, quo_den});
  assign can_num   = neg_q ? -quo_num_s : quo_num_s;

  // Shared multiplier, one product per cycle.
  logic signed [CW-1:0]   mul_a, mul_b;
  logic signed [2*CW-1:0] prod;

  always_comb begin
    case (cmd_i.mul_sel)
      PROD_LEFT: begin
        mul_a = n1_q;
        mul_b = d2_q;
      end
      PROD_RIGHT: begin
        mul_a = n2_q;
        mul_b = d1_q;
      end
      PROD_NN: begin
        mul_a = n1_q;
        mul_b = n2_q;
      end
      PROD_DD: begin
        mul_a = d1_q;
        mul_b = d2_q;
      end
      default: begin
        mul_a = d1_q;
        mul_b = n2_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Result forming from the registered products.
  logic signed [RW-1:0] f_num, f_den;
  logic                 f_flag;
  logic                 arith;

  always_comb begin
    f_num  = '0;
    f_den  = RW'(1);
    f_flag = 1'b0;
    unique case (op_q)
      OP_ADD: begin
        f_num = left_q + right_q;
        f_den = dd_q;
      end
      OP_SUB: begin
        f_num = left_q - right_q;
        f_den = dd_q;
      end
      OP_MUL: begin
        f_num = nn_q;
        f_den = dd_q;
      end
      OP_DIV: begin
        f_num = left_q;
        f_den = dn_q;
      end
      OP_EQ:   f_flag = (left_q == right_q);
      OP_GT:   f_flag = (left_q > right_q);
      OP_LT:   f_flag = (left_q < right_q);
      default: f_flag = 1'b0;
    endcase
    if (f_den == '0) begin
      f_den = RW'(1);
    end
  end

  always_comb begin
    unique case (op_q) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: arith = 1'b1;
      default:                        arith = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= rau_op_e'(command_i);
      n1_q <= CW'(first_num_i);
      n2_q <= CW'(second_num_i);
      d1_q <= (first_den_i == '0) ? CW'(1) : CW'(first_den_i);
      d2_q <= (second_den_i == '0) ? CW'(1) : CW'(second_den_i);
    end else if (cmd_i.write_back) begin
      case (cmd_i.job)
        JOB_FIRST: begin
          n1_q <= can_num[CW-1:0];
          d1_q <= quo_den_s[CW-1:0];
        end
        JOB_SECOND: begin
          n2_q <= can_num[CW-1:0];
          d2_q <= quo_den_s[CW-1:0];
        end
        default: begin
          rn_q <= can_num;
          rd_q <= quo_den_s;
        end
      endcase
    end else if (cmd_i.form) begin
      rn_q   <= f_num;
      rd_q   <= f_den;
      flag_q <= f_flag;
    end
    if (cmd_i.load_job) begin
      neg_q <= src_num[RW-1] ^ src_den[RW-1];
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        PROD_LEFT:  left_q  <= prod[RW-1:0];
        PROD_RIGHT: right_q <= prod[RW-1:0];
        PROD_NN:    nn_q    <= prod[RW-1:0];
        PROD_DD:    dd_q    <= prod[RW-1:0];
        default:    dn_q    <= prod[RW-1:0];
      endcase
    end
  end

  // Output register; wrap the result to the field widths.
  logic signed [NXW-1:0] num_ext;
  logic signed [DXW-1:0] den_ext;
  assign num_ext = NXW'(rn_q);
  assign den_ext = DXW'(rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_num_q  <= num_ext[NUM_W-1:0];
      out_den_q  <= den_ext[DEN_W-1:0];
      out_flag_q <= flag_q;
    end
  end

  assign sts_o.gcd_done    = red_sts.gcd_done;
  assign sts_o.div_done    = red_sts.div_done;
  assign sts_o.arith       = arith;
  assign sts_o.out_blocked = out_valid_q & out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign result_num_o   = out_num_q;
  assign result_den_o   = out_den_q;
  assign compare_flag_o = out_flag_q;

endmodule
`default_nettype wire

[rtl/rau_ctrl.sv]
// Controller: sequences capture, up to three reduce jobs, products and the result.
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output rau_pkg::rau_cmd_t cmd_o,
  input  rau_pkg::rau_sts_t sts_i
);
  import rau_pkg::*;

  rau_state_e state_q, state_d;
  rau_job_e   job_q, job_d;
  rau_prod_e  sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_FIRST;
      sel_q   <= PROD_LEFT;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    sel_d   = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          job_d   = JOB_FIRST;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_GCD;
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          unique case (job_q)
            JOB_FIRST: begin
              job_d   = JOB_SECOND;
              state_d = ST_LOAD;
            end
            JOB_SECOND: begin
              sel_d   = PROD_LEFT;
              state_d = ST_MUL;
            end
            JOB_RESULT: state_d = ST_OUT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        if (sel_q == PROD_DN) begin
          state_d = ST_FORM;
        end else begin
          sel_d = rau_prod_e'(sel_q + 3'd1);
        end
      end
      ST_FORM: begin
        if (sts_i.arith) begin
          job_d   = JOB_RESULT;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_blocked) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.job     = job_q;
    cmd_o.mul_sel = sel_q;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_LOAD: cmd_o.load_job = 1'b1;
      ST_GCD: begin
        cmd_o.gcd_latch = sts_i.gcd_done;
        cmd_o.gcd_step  = !sts_i.gcd_done;
      end
      ST_DIV: begin
        cmd_o.write_back = sts_i.div_done;
        cmd_o.div_step   = !sts_i.div_done;
      end
      ST_MUL:  cmd_o.mul_en   = 1'b1;
      ST_FORM: cmd_o.form     = 1'b1;
      ST_OUT:  cmd_o.out_load = !sts_i.out_blocked;
      default: cmd_o.capture  = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Rational arithmetic unit. One input word carries a command and two fractions
// (numerator and denominator, OPERAND_WIDTH-bit two's complement); one output
// word carries the reduced result with a positive denominator and a compare
// flag. A zero denominator on input reads as one. Add, subtract, multiply and
// divide give the reduced fraction and a clear flag; equal, greater and less
// give 0/1 and the flag; the unused command code gives 0/1 with a clear flag.
// Dividing by a zero fraction yields the numerator cross product over one.
// Each operand is first brought to lowest terms, then the products are
// formed one per cycle on a single multiplier, and arithmetic results are
// reduced again. Reduction runs on one shared engine: a binary gcd that takes
// one shift or subtract per cycle, then a restoring divide of numerator and
// denominator side by side, one quotient bit per cycle (OPERAND_WIDTH bits
// for an operand, twice that for a result). The number of gcd steps depends
// on the data. One item is worked on at a time: in_stall_o is low only while
// the controller is idle. A finished word sits in the output register, so
// the next input word is taken while it waits to be read.
// Results of arithmetic wrap to the 33-bit numerator and 31-bit denominator
// fields when OPERAND_WIDTH is above 16.
module rational_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rau_pkg::CMD_W-1:0]         command_i,
  input  logic signed [OPERAND_WIDTH-1:0]   first_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   first_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]   second_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   second_den_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rau_pkg::NUM_W-1:0]  result_num_o,
  output logic [rau_pkg::DEN_W-1:0]         result_den_o,
  output logic                              compare_flag_o
);
  import rau_pkg::*;

  // Command and status between controller and datapath.
  rau_cmd_t cmd;
  rau_sts_t sts;

  // Sequence the item: capture, reduce both operands, products, result.
  rau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // Hold operands, products and the output word.
  rau_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .first_num_i   (first_num_i),
    .first_den_i   (first_den_i),
    .second_num_i  (second_num_i),
    .second_den_i  (second_den_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_num_o  (result_num_o),
    .result_den_o  (result_den_o),
    .compare_flag_o(compare_flag_o)
  );

endmodule
`default_nettype wire

[rtl/rau_checker.sv]
// Port-level checks of the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rau_pkg::NUM_W-1:0]   result_num_o,
  input logic [rau_pkg::DEN_W-1:0]   result_den_o,
  input logic                        compare_flag_o
);
  import rau_pkg::*;

  // A stalled output word stays valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(result_num_o) && $stable(result_den_o) && $stable(compare_flag_o))
    else $error("output word changed while stalled");

  // A true compare comes with the fraction 0/1.
  a_flag_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_flag_o |->
      result_num_o == NUM_W'(0) && result_den_o == DEN_W'(1))
    else $error("compare result carries a nonzero fraction");

  // One item at a time: an accepted word closes the input for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in progress");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);
`default_nettype wire
